@@ sv/alm_pkg.sv @@
// ---------------------------------------------------------------------------
// alm_pkg
// shared types and constants of the audio level meter
// ---------------------------------------------------------------------------
`default_nettype none

package alm_pkg;

    localparam int MAX_CHANNELS      = 8;
    localparam int CH_BITS           = 3;
    localparam int MAX_BUFFER_FRAMES = 4096;
    localparam int FRAME_BITS        = 12;
    localparam int FRAMES_BITS       = 13;
    localparam int SAMPLE_BITS       = 16;
    localparam int RUN_BITS          = 13;
    localparam int SUM_BITS          = 43;
    localparam int LEVEL_BITS        = 31;
    localparam int STAMP_BITS        = 32;
    localparam int CFG_BITS          = 24;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int QUOT_BITS         = 64;
    localparam int ROOT_BITS         = 32;

    localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = FRAME_BITS'(MAX_BUFFER_FRAMES - 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_CHANNELS = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_RUN        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_PER_FRAME = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_FRAMES     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RMS_BLEND       = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_BITS-1:0]            channel;
        logic                          buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [CH_BITS-1:0]    bar;
        logic [LEVEL_BITS-1:0] peak_level;
        logic [LEVEL_BITS-1:0] rms_level;
        logic [LEVEL_BITS-1:0] held_peak;
        logic [LEVEL_BITS-1:0] max_peak;
        logic                  clipping;
        logic                  last;
    } out_item_t;

    // per-buffer, per-channel accumulators
    typedef struct packed {
        logic [SUM_BITS-1:0]    square_sum;
        logic [SAMPLE_BITS-1:0] peak;
        logic [RUN_BITS-1:0]    head_run;
        logic [RUN_BITS-1:0]    tail_run;
        logic                   clip_flag;
    } buf_entry_t;

    // persistent per-bar ballistics
    typedef struct packed {
        logic [RUN_BITS-1:0]   prior_tail;
        logic [LEVEL_BITS-1:0] peak_level;
        logic [LEVEL_BITS-1:0] rms_level;
        logic [LEVEL_BITS-1:0] held_peak;
        logic [STAMP_BITS-1:0] hold_stamp;
        logic [LEVEL_BITS-1:0] max_peak;
        logic                  clip_latch;
    } bar_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_BAR_READ,
        ST_BAR_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ sv/alm_vram.sv @@
// ---------------------------------------------------------------------------
// alm_vram
// per-channel synchronous memory with valid bits; an entry never written
// since reset or the last clear reads as zero
// ---------------------------------------------------------------------------
`default_nettype none

module alm_vram #(
    parameter int DATA_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clr,
    input  wire logic                        wr_en,
    input  wire logic [alm_pkg::CH_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0]        wr_data,
    input  wire logic                        rd_en,
    input  wire logic [alm_pkg::CH_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0]        rd_data
);
    import alm_pkg::*;

    logic [DATA_BITS-1:0]    mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] valid_reg;
    logic [DATA_BITS-1:0]    q_reg;
    logic                    qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end
        else
        begin
            if (clr)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                qv_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            q_reg <= mem[rd_addr];
    end

    assign rd_data = qv_reg ? q_reg : '0;

endmodule

`default_nettype wire

@@ sv/alm_div.sv @@
// ---------------------------------------------------------------------------
// alm_div
// restoring divider: floor(sum * 2^32 / frames), low 64 bits, one bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module alm_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [alm_pkg::SUM_BITS-1:0]    sum,
    input  wire logic [alm_pkg::FRAMES_BITS-1:0] frames,
    output logic                                 busy,
    output logic      [alm_pkg::QUOT_BITS-1:0]   quotient
);
    import alm_pkg::*;

    localparam int NUM_BITS = SUM_BITS + 32;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0]    num_reg;
    logic [FRAMES_BITS-1:0] rem_reg;
    logic [FRAMES_BITS-1:0] den_reg;
    logic [QUOT_BITS-1:0]   quot_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [FRAMES_BITS:0]   trial;
    logic                   fits;

    assign trial = {rem_reg, num_reg[NUM_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_BITS'(NUM_BITS);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= {sum, 32'd0};
            rem_reg  <= '0;
            den_reg  <= frames;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg  <= {num_reg[NUM_BITS-2:0], 1'b0};
            rem_reg  <= fits ? FRAMES_BITS'(trial - {1'b0, den_reg}) : trial[FRAMES_BITS-1:0];
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

@@ sv/alm_sqrt.sv @@
// ---------------------------------------------------------------------------
// alm_sqrt
// 64-bit integer square root, one result bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module alm_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [alm_pkg::QUOT_BITS-1:0] value,
    output logic                               busy,
    output logic      [alm_pkg::ROOT_BITS-1:0] root
);
    import alm_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic [QUOT_BITS-1:0] v_reg;
    logic [QUOT_BITS-1:0] res_reg;
    logic [QUOT_BITS-1:0] bit_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [QUOT_BITS:0]   trial;
    logic                 fits;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign fits  = {1'b0, v_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_BITS'(ROOT_BITS);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= {2'b01, {(QUOT_BITS-2){1'b0}}};
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                v_reg   <= v_reg - trial[QUOT_BITS-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = cnt_reg != '0;
    assign root = res_reg[ROOT_BITS-1:0];

endmodule

`default_nettype wire

@@ sv/audio_level_meter_ballistics_top.sv @@
// ---------------------------------------------------------------------------
// audio_level_meter_ballistics_top
// per-channel peak/rms level meter with decay, hold, max and clip latch
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall  | in_item_t  (sample, channel, end)
//  out     | output    | out_valid / out_stall| out_item_t (one per bar)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
//  a sample without buffer end is accepted, then goes through a read-modify-write
//  of the channel entry in the buffer memory
//  a buffer end adds a prep step, then per active bar a pass through the
//  75-step divider and the 32-step square root shared by all bars
//  a bar result waits in the output register while out_stall is high
//  reset clears control and the memory valid bits at once; no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none

module audio_level_meter_ballistics_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire alm_pkg::in_item_t                  in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output alm_pkg::out_item_t                      out_data,
    input  wire logic                               cfg_we,
    input  wire logic [alm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [alm_pkg::CFG_BITS-1:0]       cfg_data
);
    import alm_pkg::*;

    localparam int BUF_BITS = $bits(buf_entry_t);
    localparam int BAR_BITS = $bits(bar_entry_t);

    // configuration
    logic [3:0]  active_reg;
    logic [7:0]  clip_run_reg;
    logic [23:0] decay_reg;
    logic [23:0] hold_reg;
    logic [16:0] blend_reg;

    state_t state_reg, state_next;

    // captured item
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [CH_BITS-1:0]            ch_reg;
    logic                          end_reg;
    logic                          metered_reg;
    logic [FRAMES_BITS-1:0]        frames_reg;

    logic [FRAME_BITS-1:0]  frame_idx_reg;
    logic [STAMP_BITS-1:0]  elapsed_reg;
    logic [36:0]            decay_prod_reg;
    logic [CH_BITS-1:0]     bar_reg;
    logic [LEVEL_BITS-1:0]  rms_reg;
    logic [47:0]            p_old_reg;
    logic [47:0]            p_new_reg;
    out_item_t              out_reg;
    logic                   out_valid_reg;

    logic [3:0]  nact;
    logic [16:0] blend_eff;
    logic        in_xfer;
    logic        out_free;
    logic        last_bar;

    // memory ports
    logic                buf_rd_en;
    logic [CH_BITS-1:0]  buf_rd_addr;
    logic [BUF_BITS-1:0] buf_rd_bits;
    logic                buf_wr_en;
    logic                buf_clr;
    buf_entry_t          buf_q;
    buf_entry_t          buf_upd;
    logic                bar_rd_en;
    logic                bar_wr_en;
    logic [BAR_BITS-1:0] bar_rd_bits;
    bar_entry_t          bar_q;
    bar_entry_t          bar_upd;

    logic                   div_start;
    logic                   div_busy;
    logic [QUOT_BITS-1:0]   div_quot;
    logic                   sq_start;
    logic                   sq_busy;
    logic [ROOT_BITS-1:0]   sq_root;

    // sample update terms
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] mag_sq;
    logic                     clipped;
    logic [SUM_BITS:0]        sum_wide;
    logic [RUN_BITS-1:0]      tail_new;

    // bar result terms
    logic [LEVEL_BITS-1:0]  bpk;
    logic [LEVEL_BITS-1:0]  dec;
    logic [LEVEL_BITS-1:0]  pk;
    logic [48:0]            sm_sum;
    logic [STAMP_BITS-1:0]  age;
    logic                   refresh;
    logic [RUN_BITS:0]      run_join;

    assign nact      = (active_reg == 4'd0) ? 4'd1 :
                       (active_reg > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : active_reg;
    assign blend_eff = (blend_reg > 17'd65536) ? 17'd65536 : blend_reg;
    assign in_stall  = state_reg != ST_IDLE;
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_bar  = {1'b0, bar_reg} == (nact - 4'd1);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 4'd2;
            clip_run_reg <= 8'd3;
            decay_reg    <= 24'd44739;
            hold_reg     <= 24'd144000;
            blend_reg    <= 17'd52429;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_CHANNELS: active_reg   <= cfg_data[3:0];
                CFG_CLIP_RUN:        clip_run_reg <= cfg_data[7:0];
                CFG_DECAY_PER_FRAME: decay_reg    <= cfg_data;
                CFG_HOLD_FRAMES:     hold_reg     <= cfg_data;
                CFG_RMS_BLEND:       blend_reg    <= cfg_data[16:0];
                default:             ;
            endcase
        end
    end

    // buffer memory: sums, peaks and clip runs of the current buffer
    assign buf_rd_en   = in_xfer || (state_reg == ST_BAR_READ);
    assign buf_rd_addr = (state_reg == ST_IDLE) ? in_data.channel : bar_reg;
    assign buf_wr_en   = (state_reg == ST_UPDATE) && metered_reg;
    assign buf_clr     = (state_reg == ST_EMIT) && out_free && last_bar;
    assign buf_q       = buf_entry_t'(buf_rd_bits);

    alm_vram #(.DATA_BITS(BUF_BITS)) u_buf_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (buf_clr),
        .wr_en   (buf_wr_en),
        .wr_addr (ch_reg),
        .wr_data (BUF_BITS'(buf_upd)),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_bits)
    );

    // bar memory: ballistics kept since reset
    assign bar_rd_en = state_reg == ST_BAR_READ;
    assign bar_wr_en = (state_reg == ST_EMIT) && out_free;
    assign bar_q     = bar_entry_t'(bar_rd_bits);

    alm_vram #(.DATA_BITS(BAR_BITS)) u_bar_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (1'b0),
        .wr_en   (bar_wr_en),
        .wr_addr (bar_reg),
        .wr_data (BAR_BITS'(bar_upd)),
        .rd_en   (bar_rd_en),
        .rd_addr (bar_reg),
        .rd_data (bar_rd_bits)
    );

    assign div_start = state_reg == ST_BAR_LOAD;
    assign sq_start  = (state_reg == ST_DIV) && !div_busy;

    alm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (buf_q.square_sum),
        .frames   (frames_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    alm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (div_quot),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    // per-sample read-modify-write of the channel entry
    always_comb
    begin
        mag      = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
        mag_sq   = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
        clipped  = mag >= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        sum_wide = {1'b0, buf_q.square_sum} + (SUM_BITS+1)'(mag_sq);
        buf_upd  = buf_q;
        buf_upd.square_sum = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
        if (mag > buf_q.peak)
            buf_upd.peak = mag;
        tail_new = '0;
        if (clipped)
        begin
            if ((buf_q.head_run == {1'b0, frame_idx_reg}) && (buf_q.head_run != RUN_MAX))
                buf_upd.head_run = buf_q.head_run + 1'b1;
            tail_new = (buf_q.tail_run != RUN_MAX) ? buf_q.tail_run + 1'b1 : buf_q.tail_run;
            if (tail_new > {5'd0, clip_run_reg})
                buf_upd.clip_flag = 1'b1;
        end
        buf_upd.tail_run = tail_new;
    end

    // per-bar ballistics at buffer end
    always_comb
    begin
        bpk = buf_q.peak[SAMPLE_BITS-1] ? LEVEL_MAX : {buf_q.peak[14:0], 16'd0};
        dec = ({6'd0, bar_q.peak_level} > decay_prod_reg) ?
              LEVEL_BITS'({6'd0, bar_q.peak_level} - decay_prod_reg) : '0;
        pk  = (bpk > dec) ? bpk : dec;
        sm_sum   = {1'b0, p_old_reg} + {1'b0, p_new_reg} + 49'd32768;
        age      = elapsed_reg - bar_q.hold_stamp;
        refresh  = (age > {8'd0, hold_reg}) || (pk > bar_q.held_peak);
        run_join = {1'b0, bar_q.prior_tail} + {1'b0, buf_q.head_run};

        bar_upd            = bar_q;
        bar_upd.peak_level = pk;
        bar_upd.rms_level  = sm_sum[LEVEL_BITS+15:16];
        if (refresh)
        begin
            bar_upd.held_peak  = pk;
            bar_upd.hold_stamp = elapsed_reg;
        end
        if (pk > bar_q.max_peak)
            bar_upd.max_peak = pk;
        if (buf_q.clip_flag || (run_join >= {6'd0, clip_run_reg}))
            bar_upd.clip_latch = 1'b1;
        bar_upd.prior_tail = buf_q.tail_run;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_xfer) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = end_reg ? ST_PREP : ST_IDLE;
            ST_PREP:     state_next = ST_BAR_READ;
            ST_BAR_READ: state_next = ST_BAR_LOAD;
            ST_BAR_LOAD: state_next = ST_DIV;
            ST_DIV:      if (!div_busy) state_next = ST_SQRT;
            ST_SQRT:     if (!sq_busy) state_next = ST_MUL_OLD;
            ST_MUL_OLD:  state_next = ST_MUL_NEW;
            ST_MUL_NEW:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = last_bar ? ST_IDLE : ST_BAR_READ;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_idx_reg <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            bar_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
            begin
                if (metered_reg && ({1'b0, ch_reg} == (nact - 4'd1))
                    && (frame_idx_reg != FRAME_MAX))
                    frame_idx_reg <= frame_idx_reg + 1'b1;
                if (end_reg)
                begin
                    elapsed_reg <= elapsed_reg + STAMP_BITS'(frames_reg);
                    bar_reg     <= '0;
                end
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                if (last_bar)
                    frame_idx_reg <= '0;
                else
                    bar_reg <= bar_reg + 1'b1;
            end
            if ((state_reg == ST_EMIT) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg  <= in_data.sample;
            ch_reg      <= in_data.channel;
            end_reg     <= in_data.buffer_end;
            metered_reg <= {1'b0, in_data.channel} < nact;
            frames_reg  <= {1'b0, frame_idx_reg} + 1'b1;
        end
        if (state_reg == ST_PREP)
            decay_prod_reg <= 37'(decay_reg) * 37'(frames_reg);
        if ((state_reg == ST_SQRT) && !sq_busy)
            rms_reg <= sq_root[ROOT_BITS-1] ? LEVEL_MAX : sq_root[LEVEL_BITS-1:0];
        if (state_reg == ST_MUL_OLD)
            p_old_reg <= 48'(bar_q.rms_level) * 48'(17'd65536 - blend_eff);
        if (state_reg == ST_MUL_NEW)
            p_new_reg <= 48'(rms_reg) * 48'(blend_eff);
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_reg.bar        <= bar_reg;
            out_reg.peak_level <= bar_upd.peak_level;
            out_reg.rms_level  <= bar_upd.rms_level;
            out_reg.held_peak  <= bar_upd.held_peak;
            out_reg.max_peak   <= bar_upd.max_peak;
            out_reg.clipping   <= bar_upd.clip_latch;
            out_reg.last       <= last_bar;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
